// ===== design/kpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad password lock package
// Shared types, codes and constants for the keypad password lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

	localparam int PASS_DIGITS = 5;
	localparam int POS_W       = $clog2(PASS_DIGITS + 1);
	localparam int IDX_W       = (PASS_DIGITS > 1) ? $clog2(PASS_DIGITS) : 1;

	localparam int DIGIT_W     = 4;
	localparam int KEY_W       = 8;
	localparam int EVENT_W     = 4;
	localparam int DIGITS_W    = 3;
	localparam int ATT_W       = 4;
	localparam int TICK_W      = 16;
	localparam int BLINK_W     = 10;
	localparam int PHASE_W     = 3;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 2'd3;

	localparam logic [ATT_W-1:0]   ATT_RESET   = 4'd3;
	localparam logic [TICK_W-1:0]  OPEN_RESET  = 16'd5000;
	localparam logic [TICK_W-1:0]  LOCK_RESET  = 16'd2500;
	localparam logic [BLINK_W-1:0] BLINK_RESET = 10'd50;

	localparam logic [KEY_W-1:0] KEY_EQ   = 8'h3D;
	localparam logic [KEY_W-1:0] KEY_CONF = 8'h43;
	localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
	localparam logic [KEY_W-1:0] KEY_9    = 8'h39;

	typedef enum logic [PHASE_W-1:0] {
		PH_SETUP = 3'd0,
		PH_ENTER = 3'd1,
		PH_OLD   = 3'd2,
		PH_NEW   = 3'd3,
		PH_OPEN  = 3'd4,
		PH_LOCK  = 3'd5
	} phase_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE     = 4'd0,
		EV_DIGIT    = 4'd1,
		EV_SET      = 4'd2,
		EV_OPEN     = 4'd3,
		EV_WRONG    = 4'd4,
		EV_LOCKOUT  = 4'd5,
		EV_CHANGE   = 4'd6,
		EV_BADOLD   = 4'd7,
		EV_OLDOK    = 4'd8,
		EV_CHANGED  = 4'd9,
		EV_CLOSED   = 4'd10,
		EV_UNLOCKED = 4'd11
	} event_t;

	typedef struct packed {
		logic [ATT_W-1:0]   attempts_allowed;
		logic [TICK_W-1:0]  open_ticks;
		logic [TICK_W-1:0]  lockout_ticks;
		logic [BLINK_W-1:0] blink_ticks;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic [ATT_W-1:0] value;
	} att_wr_t;

	typedef struct packed {
		logic                door_open;
		logic                buzzer_on;
		logic                alarm_led;
		logic [EVENT_W-1:0]  event_res;
		logic [DIGITS_W-1:0] digits_entered;
		logic [ATT_W-1:0]    attempts_left;
		logic [PHASE_W-1:0]  lock_phase;
	} res_t;

endpackage

// ===== design/kpl_if.sv =====
// ----------------------------------------------------------------------------
// Keypad password lock channels
// Valid/ready channels for key and tick items and for result items.
// ----------------------------------------------------------------------------
interface kpl_in_if;
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [kpl_pkg::KEY_W-1:0] key_code;

	modport source (output valid, output func, output key_code, input ready);
	modport sink (input valid, input func, input key_code, output ready);
endinterface

interface kpl_out_if;
	logic                          valid;
	logic                          ready;
	logic                          door_open;
	logic                          buzzer_on;
	logic                          alarm_led;
	logic [kpl_pkg::EVENT_W-1:0]   event_res;
	logic [kpl_pkg::DIGITS_W-1:0]  digits_entered;
	logic [kpl_pkg::ATT_W-1:0]     attempts_left;
	logic [kpl_pkg::PHASE_W-1:0]   lock_phase;

	modport source (output valid, output door_open, output buzzer_on, output alarm_led,
		output event_res, output digits_entered, output attempts_left,
		output lock_phase, input ready);
	modport sink (input valid, input door_open, input buzzer_on, input alarm_led,
		input event_res, input digits_entered, input attempts_left,
		input lock_phase, output ready);
endinterface

// ===== design/kpl_cfg.sv =====
// ----------------------------------------------------------------------------
// Keypad password lock configuration registers
// Holds the attempt count and the timing registers written over the port.
// ----------------------------------------------------------------------------
module kpl_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kpl_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [kpl_pkg::CFG_DATA_W-1:0]   cfg_data,
	output kpl_pkg::cfg_t                    cfg,
	output kpl_pkg::att_wr_t                 att_wr
);

	kpl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attempts_allowed <= kpl_pkg::ATT_RESET;
			cfg_q.open_ticks       <= kpl_pkg::OPEN_RESET;
			cfg_q.lockout_ticks    <= kpl_pkg::LOCK_RESET;
			cfg_q.blink_ticks      <= kpl_pkg::BLINK_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				kpl_pkg::CFG_ATTEMPTS: begin
					cfg_q.attempts_allowed <= cfg_data[kpl_pkg::ATT_W-1:0];
				end
				kpl_pkg::CFG_OPEN: begin
					cfg_q.open_ticks <= cfg_data[kpl_pkg::TICK_W-1:0];
				end
				kpl_pkg::CFG_LOCKOUT: begin
					cfg_q.lockout_ticks <= cfg_data[kpl_pkg::TICK_W-1:0];
				end
				kpl_pkg::CFG_BLINK: begin
					cfg_q.blink_ticks <= cfg_data[kpl_pkg::BLINK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg          = cfg_q;
	assign att_wr.load  = cfg_we && (cfg_idx == kpl_pkg::CFG_ATTEMPTS);
	assign att_wr.value = cfg_data[kpl_pkg::ATT_W-1:0];

endmodule

// ===== design/kpl_core.sv =====
// ----------------------------------------------------------------------------
// Keypad password lock core
// Lock state and the update that one key or tick item causes.
// ----------------------------------------------------------------------------
module kpl_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic                          func,
	input  logic [kpl_pkg::KEY_W-1:0]     key_code,
	input  kpl_pkg::cfg_t                 cfg,
	input  kpl_pkg::att_wr_t              att_wr,
	output kpl_pkg::res_t                 res
);

	kpl_pkg::phase_t                                          phase_q, phase_n;
	logic [kpl_pkg::PASS_DIGITS-1:0][kpl_pkg::DIGIT_W-1:0]    pw_q, pw_n;
	logic [kpl_pkg::PASS_DIGITS-1:0][kpl_pkg::DIGIT_W-1:0]    dig_q, dig_n;
	logic [kpl_pkg::POS_W-1:0]                                pos_q, pos_n;
	logic [kpl_pkg::ATT_W-1:0]                                att_q, att_n;
	logic [kpl_pkg::TICK_W-1:0]                               ptim_q, ptim_n;
	logic [kpl_pkg::BLINK_W-1:0]                              btim_q, btim_n, btim_inc;
	logic                                                     led_q, led_n;
	kpl_pkg::event_t                                          ev;
	logic                                                     fin;
	logic                                                     match;
	logic [kpl_pkg::KEY_W-1:0]                                key_off;

	assign match    = (pw_q == dig_q);
	assign key_off  = key_code - kpl_pkg::KEY_0;
	assign btim_inc = btim_q + kpl_pkg::BLINK_W'(1);

	always_comb begin
		phase_n = phase_q;
		pw_n    = pw_q;
		dig_n   = dig_q;
		pos_n   = pos_q;
		att_n   = att_q;
		ptim_n  = ptim_q;
		btim_n  = btim_q;
		led_n   = led_q;
		ev      = kpl_pkg::EV_NONE;
		fin     = 1'b0;
		if (func) begin
			if (phase_q == kpl_pkg::PH_OPEN) begin
				if (ptim_q <= kpl_pkg::TICK_W'(1)) begin
					ptim_n  = '0;
					phase_n = kpl_pkg::PH_ENTER;
					pos_n   = '0;
					ev      = kpl_pkg::EV_CLOSED;
				end else begin
					ptim_n = ptim_q - kpl_pkg::TICK_W'(1);
				end
			end else if (phase_q == kpl_pkg::PH_LOCK) begin
				if (ptim_q <= kpl_pkg::TICK_W'(1)) begin
					ptim_n  = '0;
					btim_n  = '0;
					led_n   = 1'b0;
					att_n   = cfg.attempts_allowed;
					phase_n = kpl_pkg::PH_ENTER;
					pos_n   = '0;
					ev      = kpl_pkg::EV_UNLOCKED;
				end else begin
					ptim_n = ptim_q - kpl_pkg::TICK_W'(1);
					if (btim_inc >= cfg.blink_ticks) begin
						btim_n = '0;
						led_n  = ~led_q;
					end else begin
						btim_n = btim_inc;
					end
				end
			end
		end else if (phase_q == kpl_pkg::PH_SETUP || phase_q == kpl_pkg::PH_ENTER ||
				phase_q == kpl_pkg::PH_OLD || phase_q == kpl_pkg::PH_NEW) begin
			if (pos_q < kpl_pkg::POS_W'(kpl_pkg::PASS_DIGITS)) begin
				if (key_code == kpl_pkg::KEY_EQ) begin
					if (phase_q == kpl_pkg::PH_ENTER) begin
						dig_n   = '0;
						pos_n   = '0;
						phase_n = kpl_pkg::PH_OLD;
						ev      = kpl_pkg::EV_CHANGE;
					end else begin
						fin = 1'b1;
					end
				end else if (key_code >= kpl_pkg::KEY_0 && key_code <= kpl_pkg::KEY_9) begin
					dig_n[pos_q[kpl_pkg::IDX_W-1:0]] = key_off[kpl_pkg::DIGIT_W-1:0];
					pos_n = pos_q + kpl_pkg::POS_W'(1);
					ev    = kpl_pkg::EV_DIGIT;
				end
			end else if (key_code == kpl_pkg::KEY_CONF) begin
				fin = 1'b1;
			end
		end

		if (fin) begin
			pos_n = '0;
			case (phase_q)
				kpl_pkg::PH_SETUP: begin
					pw_n    = dig_q;
					phase_n = kpl_pkg::PH_ENTER;
					ev      = kpl_pkg::EV_SET;
				end
				kpl_pkg::PH_ENTER: begin
					if (match) begin
						phase_n = kpl_pkg::PH_OPEN;
						ptim_n  = cfg.open_ticks;
						ev      = kpl_pkg::EV_OPEN;
					end else if (att_q <= kpl_pkg::ATT_W'(1)) begin
						att_n   = '0;
						phase_n = kpl_pkg::PH_LOCK;
						ptim_n  = cfg.lockout_ticks;
						btim_n  = '0;
						led_n   = 1'b0;
						ev      = kpl_pkg::EV_LOCKOUT;
					end else begin
						att_n = att_q - kpl_pkg::ATT_W'(1);
						ev    = kpl_pkg::EV_WRONG;
					end
				end
				kpl_pkg::PH_OLD: begin
					if (match) begin
						phase_n = kpl_pkg::PH_NEW;
						ev      = kpl_pkg::EV_OLDOK;
					end else begin
						phase_n = kpl_pkg::PH_ENTER;
						ev      = kpl_pkg::EV_BADOLD;
					end
				end
				kpl_pkg::PH_NEW: begin
					pw_n    = dig_q;
					phase_n = kpl_pkg::PH_ENTER;
					ev      = kpl_pkg::EV_CHANGED;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kpl_pkg::PH_SETUP;
			dig_q   <= '0;
			pos_q   <= '0;
			att_q   <= kpl_pkg::ATT_RESET;
			ptim_q  <= '0;
			btim_q  <= '0;
			led_q   <= 1'b0;
		end else if (att_wr.load) begin
			att_q <= att_wr.value;
		end else if (go) begin
			phase_q <= phase_n;
			dig_q   <= dig_n;
			pos_q   <= pos_n;
			att_q   <= att_n;
			ptim_q  <= ptim_n;
			btim_q  <= btim_n;
			led_q   <= led_n;
		end
	end

	// The stored password has no reset; it is always set in the setup phase before use.
	always_ff @(posedge clk) begin
		if (go) begin
			pw_q <= pw_n;
		end
	end

	assign res.door_open      = (phase_n == kpl_pkg::PH_OPEN);
	assign res.buzzer_on      = (phase_n == kpl_pkg::PH_LOCK);
	assign res.alarm_led      = (phase_n == kpl_pkg::PH_LOCK) && led_n;
	assign res.event_res      = ev;
	assign res.digits_entered = kpl_pkg::DIGITS_W'(pos_n);
	assign res.attempts_left  = att_n;
	assign res.lock_phase     = phase_n;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= kpl_pkg::POS_W'(kpl_pkg::PASS_DIGITS))
		else $error("entry position beyond the password length");

	a_open_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == kpl_pkg::PH_OPEN || phase_q == kpl_pkg::PH_LOCK) |-> pos_q == '0)
		else $error("digits held while the door is open or locked out");

	a_led_off_outside_lock: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != kpl_pkg::PH_LOCK |-> (!led_q && btim_q == '0))
		else $error("blink state active outside lockout");

	a_tick_keeps_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(go && func && !att_wr.load && phase_q == kpl_pkg::PH_SETUP)
		|=> phase_q == kpl_pkg::PH_SETUP)
		else $error("tick item left the setup phase");
`endif

endmodule

// ===== design/keypad_password_lock.sv =====
// ----------------------------------------------------------------------------
// Keypad password lock
// Takes key and tick items and runs the setup, entry, change, open and lockout
// phases of a keypad combination lock, giving one result item per input item.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// key_in    sink       func, key_code
// res_out   source     door_open, buzzer_on, alarm_led, event_res,
//                      digits_entered, attempts_left, lock_phase
// cfg_*     write      attempts_allowed, open_ticks, lockout_ticks, blink_ticks
//
// One item is accepted per clock while the output is not stalled; each item passes
// through the input register and then the output register.
// The item's whole state update is computed combinationally out of the input register.
// A stalled output holds its result and stops the input register, which then
// drops key_in.ready. Reset restores the configuration defaults and the setup
// phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keypad_password_lock (
	input  logic                           clk,
	input  logic                           arst_n,
	kpl_in_if.sink                         key_in,
	kpl_out_if.source                      res_out,
	input  logic                           cfg_we,
	input  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [kpl_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                      vld_s1;
	logic                      func_s1;
	logic [kpl_pkg::KEY_W-1:0] key_s1;
	logic                      out_vld_q;
	kpl_pkg::res_t             res_q;
	kpl_pkg::res_t             res;
	kpl_pkg::cfg_t             cfg;
	kpl_pkg::att_wr_t          att_wr;
	logic                      go;
	logic                      take;

	assign go           = vld_s1 && (!out_vld_q || res_out.ready);
	assign take         = key_in.valid && key_in.ready;
	assign key_in.ready = !vld_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (key_in.ready) begin
			vld_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= key_in.func;
			key_s1  <= key_in.key_code;
		end
	end

	kpl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.att_wr   (att_wr)
	);

	kpl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.func     (func_s1),
		.key_code (key_s1),
		.cfg      (cfg),
		.att_wr   (att_wr),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (go) begin
			out_vld_q <= 1'b1;
		end else if (res_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res;
		end
	end

	assign res_out.valid          = out_vld_q;
	assign res_out.door_open      = res_q.door_open;
	assign res_out.buzzer_on      = res_q.buzzer_on;
	assign res_out.alarm_led      = res_q.alarm_led;
	assign res_out.event_res      = res_q.event_res;
	assign res_out.digits_entered = res_q.digits_entered;
	assign res_out.attempts_left  = res_q.attempts_left;
	assign res_out.lock_phase     = res_q.lock_phase;

endmodule
